// ===== design/fixed_block_pool_allocator_defines.svh =====
// ----------------------------------------------------------------------------
// Fixed block pool allocator assertion macros
// Concurrent checks on the rising clock edge, dropped when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH

`ifndef SYNTH
`define FBPA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error(msg);
`define FBPA_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
`else
`define FBPA_ASSERT(lbl, clk, rstn, prop, msg)
`define FBPA_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== design/fbpa_pkg.sv =====
// ----------------------------------------------------------------------------
// Fixed block pool allocator package
// Field widths, command and status codes, register indexes and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package fbpa_pkg;

    localparam int DEFAULT_MAX_BLOCKS = 64;

    localparam int CMD_W       = 2;
    localparam int OFFSET_W    = 22;
    localparam int INDEX_W     = 6;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 7;
    localparam int BYTES_W     = 16;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CMD_W-1:0] CMD_ALLOC    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FREE_ALL = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL       = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_OFFSET = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_COUNT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_BYTES = 1'd1;

    localparam logic [COUNT_W-1:0] BLOCK_COUNT_RESET = 7'd64;
    localparam logic [BYTES_W-1:0] BLOCK_BYTES_RESET = 16'd256;

    typedef enum logic [2:0] {
        OUT_GRANT,
        OUT_FREED,
        OUT_FULL,
        OUT_BAD_OFFSET,
        OUT_ZERO
    } out_sel_t;

    typedef struct packed {
        logic     start;
        logic     step;
        logic     set_used;
        logic     clr_used;
        logic     out_load;
        out_sel_t out_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic at_end;
        logic slot_free;
        logic offset_hit;
        logic sweep_last;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== design/fbpa_datapath.sv =====
// ----------------------------------------------------------------------------
// Fixed block pool allocator datapath
// Configuration registers, walk index with running offset, occupancy
// memory and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpa_datapath
    import fbpa_pkg::*;
#(
    parameter int MAX_BLOCKS = DEFAULT_MAX_BLOCKS
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire dp_cmd_t                ctl,
    input  wire logic [OFFSET_W-1:0]    free_offset,
    output dp_stat_t                    stat,
    output logic                        granted,
    output logic [INDEX_W-1:0]          block_index,
    output logic [OFFSET_W-1:0]         block_offset,
    output logic [STATUS_W-1:0]         status
);

    localparam int CW  = $clog2(MAX_BLOCKS + 1);
    localparam int AW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int RW0 = BYTES_W + CW;
    localparam int RW  = (RW0 > OFFSET_W) ? RW0 : OFFSET_W;
    localparam int IW  = (CW > INDEX_W) ? CW : INDEX_W;
    localparam logic [CW-1:0] LAST_IDX = CW'(MAX_BLOCKS - 1);
    localparam logic [CW-1:0] MAX_IDX  = CW'(MAX_BLOCKS);

    logic [COUNT_W-1:0]  block_count_reg;
    logic [BYTES_W-1:0]  block_bytes_reg;
    logic [CW-1:0]       idx_reg;
    logic [CW-1:0]       idx_next;
    logic [CW-1:0]       limit_reg;
    logic [CW-1:0]       limit_next;
    logic [RW-1:0]       running_reg;
    logic [RW-1:0]       running_next;
    logic [OFFSET_W-1:0] target_reg;
    logic                rd_data_reg;
    logic [AW-1:0]       rd_addr;
    logic [IW-1:0]       idx_wide;
    logic                used_mem [MAX_BLOCKS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_count_reg <= BLOCK_COUNT_RESET;
            block_bytes_reg <= BLOCK_BYTES_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_BLOCK_COUNT: block_count_reg <= cfg_data[COUNT_W-1:0];
                REG_BLOCK_BYTES: block_bytes_reg <= cfg_data[BYTES_W-1:0];
                default:         block_count_reg <= block_count_reg;
            endcase
        end
    end

    always_comb
    begin
        if (32'(block_count_reg) < 32'(MAX_BLOCKS))
            limit_next = CW'(block_count_reg);
        else
            limit_next = MAX_IDX;

        if (ctl.start)
        begin
            idx_next     = '0;
            running_next = '0;
        end
        else if (ctl.step)
        begin
            idx_next     = idx_reg + CW'(1);
            running_next = running_reg + RW'(block_bytes_reg);
        end
        else
        begin
            idx_next     = idx_reg;
            running_next = running_reg;
        end
    end

    assign rd_addr = idx_next[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else
            idx_reg <= idx_next;
    end

    always_ff @(posedge clk)
    begin
        running_reg <= running_next;
        if (ctl.start)
        begin
            limit_reg  <= limit_next;
            target_reg <= free_offset;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.set_used)
            used_mem[idx_reg[AW-1:0]] <= 1'b1;
        else if (ctl.clr_used)
            used_mem[idx_reg[AW-1:0]] <= 1'b0;
        rd_data_reg <= used_mem[rd_addr];
    end

    assign stat.at_end     = (idx_reg >= limit_reg);
    assign stat.slot_free  = !rd_data_reg;
    assign stat.offset_hit = (running_reg == RW'(target_reg));
    assign stat.sweep_last = (idx_reg == LAST_IDX);

    assign idx_wide = IW'(idx_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            case (ctl.out_sel)
                OUT_GRANT:
                begin
                    granted      <= 1'b1;
                    block_index  <= idx_wide[INDEX_W-1:0];
                    block_offset <= running_reg[OFFSET_W-1:0];
                    status       <= STATUS_OK;
                end
                OUT_FREED:
                begin
                    granted      <= 1'b0;
                    block_index  <= idx_wide[INDEX_W-1:0];
                    block_offset <= '0;
                    status       <= STATUS_OK;
                end
                OUT_FULL:
                begin
                    granted      <= 1'b0;
                    block_index  <= '0;
                    block_offset <= '0;
                    status       <= STATUS_FULL;
                end
                OUT_BAD_OFFSET:
                begin
                    granted      <= 1'b0;
                    block_index  <= '0;
                    block_offset <= '0;
                    status       <= STATUS_BAD_OFFSET;
                end
                default:
                begin
                    granted      <= 1'b0;
                    block_index  <= '0;
                    block_offset <= '0;
                    status       <= STATUS_OK;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== design/fbpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// Fixed block pool allocator controller
// Sequences the clearing pass, the allocate and free walks, the free-all
// sweep and the hand-off of each result beat to the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "fixed_block_pool_allocator_defines.svh"

module fbpa_ctrl
    import fbpa_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_stall,
    input  wire logic [CMD_W-1:0] cmd,
    output logic                  rsp_valid,
    input  wire logic             rsp_stall,
    output dp_cmd_t               ctl,
    input  wire dp_stat_t         stat
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ALLOC,
        ST_FREE,
        ST_SWEEP,
        ST_ZERO
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   slot_ok;

    assign slot_ok   = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        ctl.out_sel = OUT_ZERO;

        case (state_reg)
            ST_CLEAR:
            begin
                ctl.clr_used = 1'b1;
                ctl.step     = 1'b1;
                if (stat.sweep_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    ctl.start = 1'b1;
                    case (cmd)
                        CMD_ALLOC:    state_next = ST_ALLOC;
                        CMD_FREE:     state_next = ST_FREE;
                        CMD_FREE_ALL: state_next = ST_SWEEP;
                        default:      state_next = ST_ZERO;
                    endcase
                end
            end
            ST_ALLOC:
            begin
                if (stat.at_end)
                begin
                    if (slot_ok)
                    begin
                        ctl.out_load = 1'b1;
                        ctl.out_sel  = OUT_FULL;
                        state_next   = ST_IDLE;
                    end
                end
                else if (stat.slot_free)
                begin
                    if (slot_ok)
                    begin
                        ctl.set_used = 1'b1;
                        ctl.out_load = 1'b1;
                        ctl.out_sel  = OUT_GRANT;
                        state_next   = ST_IDLE;
                    end
                end
                else
                    ctl.step = 1'b1;
            end
            ST_FREE:
            begin
                if (stat.at_end)
                begin
                    if (slot_ok)
                    begin
                        ctl.out_load = 1'b1;
                        ctl.out_sel  = OUT_BAD_OFFSET;
                        state_next   = ST_IDLE;
                    end
                end
                else if (stat.offset_hit)
                begin
                    if (slot_ok)
                    begin
                        ctl.clr_used = 1'b1;
                        ctl.out_load = 1'b1;
                        ctl.out_sel  = OUT_FREED;
                        state_next   = ST_IDLE;
                    end
                end
                else
                    ctl.step = 1'b1;
            end
            ST_SWEEP:
            begin
                ctl.clr_used = 1'b1;
                ctl.step     = 1'b1;
                if (stat.sweep_last)
                    state_next = ST_ZERO;
            end
            ST_ZERO:
            begin
                if (slot_ok)
                begin
                    ctl.out_load = 1'b1;
                    ctl.out_sel  = OUT_ZERO;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase

        if (ctl.out_load)
            rsp_valid_next = 1'b1;
        else if (!rsp_stall)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    `FBPA_ASSERT(a_no_result_overwrite, clk, rst_n, !(ctl.out_load && rsp_valid_reg && rsp_stall), "result beat overwritten while stalled")
    `FBPA_ASSERT_IMPLY(a_grant_on_free_slot, clk, rst_n, ctl.set_used, stat.slot_free && !stat.at_end && state_reg == ST_ALLOC, "block marked used without a free slot in range")
    `FBPA_ASSERT_IMPLY(a_free_on_hit, clk, rst_n, ctl.clr_used && state_reg == ST_FREE, stat.offset_hit && !stat.at_end, "block cleared without an offset match")

endmodule

`default_nettype wire

// ===== design/fixed_block_pool_allocator.sv =====
// ----------------------------------------------------------------------------
// Fixed block pool allocator
// Allocate: answers with the lowest free block among the first n blocks;
// pool full when none of them is free, n = min(block_count, MAX_BLOCKS).
// Free by offset: answers with the block whose start matches, else a bad offset.
// Free all: clears every map entry, one map entry per cycle through the walk.
// Reset: clearing pass over all MAX_BLOCKS map entries, no request taken.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_block_pool_allocator
    import fbpa_pkg::*;
#(
    parameter int MAX_BLOCKS = DEFAULT_MAX_BLOCKS
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   req_valid,
    output logic                        req_stall,
    input  wire logic [CMD_W-1:0]       cmd,
    input  wire logic [OFFSET_W-1:0]    free_offset,
    output logic                        rsp_valid,
    input  wire logic                   rsp_stall,
    output logic                        granted,
    output logic [INDEX_W-1:0]          block_index,
    output logic [OFFSET_W-1:0]         block_offset,
    output logic [STATUS_W-1:0]         status,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    dp_cmd_t  ctl;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    fbpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .ctl       (ctl),
        .stat      (stat)
    );

    fbpa_datapath #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .ctl          (ctl),
        .free_offset  (free_offset),
        .stat         (stat),
        .granted      (granted),
        .block_index  (block_index),
        .block_offset (block_offset),
        .status       (status)
    );

endmodule

`default_nettype wire

// ===== tb/fixed_block_pool_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// Fixed block pool allocator testbench
// Drives allocate, free-by-offset, free-all and unused commands through the
// request channel under several pool geometries (including zero blocks, an
// out-of-range count, zero-byte and maximum-size blocks). A local occupancy
// map predicts every answer, which is checked field by field in order. The
// requests idle and answers stall at random; one phase holds off the answers
// long enough for the request side to back up.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module fixed_block_pool_allocator_tb
    import fbpa_pkg::*;
;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = DEFAULT_MAX_BLOCKS + 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TARGET_ITEMS   = 2000;
    localparam int JUNK_W         = CFG_DATA_W - COUNT_W;

    typedef struct packed {
        logic [CMD_W-1:0]    op;
        logic [OFFSET_W-1:0] offset;
    } pool_req_t;

    typedef struct packed {
        logic                granted;
        logic [INDEX_W-1:0]  index;
        logic [OFFSET_W-1:0] offset;
        logic [STATUS_W-1:0] status;
    } pool_rsp_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   req_valid = 1'b0;
    logic                   req_stall;
    logic [CMD_W-1:0]       cmd = CMD_ALLOC;
    logic [OFFSET_W-1:0]    free_offset = '0;
    logic                   rsp_valid;
    logic                   rsp_stall = 1'b0;
    logic                   granted;
    logic [INDEX_W-1:0]     block_index;
    logic [OFFSET_W-1:0]    block_offset;
    logic [STATUS_W-1:0]    status;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_BLOCK_COUNT;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    pool_req_t queued_requests[$];
    pool_rsp_t pending_answers[$];

    logic [DEFAULT_MAX_BLOCKS-1:0] used_blocks = '0;
    logic [COUNT_W-1:0]            cfg_count = BLOCK_COUNT_RESET;
    logic [BYTES_W-1:0]            cfg_bytes = BLOCK_BYTES_RESET;

    int  fault_count = 0;
    int  send_gap = 0;
    int  stall_left = 0;
    int  hold_asks = 0;
    int  hold_done = 0;
    int  idle_cycles = 0;
    bit  calm = 1'b0;

    fixed_block_pool_allocator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .cmd          (cmd),
        .free_offset  (free_offset),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .granted      (granted),
        .block_index  (block_index),
        .block_offset (block_offset),
        .status       (status),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic int active_count();
        return (cfg_count < DEFAULT_MAX_BLOCKS) ? int'(cfg_count) : DEFAULT_MAX_BLOCKS;
    endfunction

    // Apply one command to the occupancy map and return the answer it earns.
    function automatic pool_rsp_t pool_answer(logic [CMD_W-1:0] op,
                                              logic [OFFSET_W-1:0] target);
        pool_rsp_t         ans;
        longint unsigned   running;
        int                n;
        int                i;
        bit                hit;
        ans = '0;
        running = 0;
        n = active_count();
        i = 0;
        hit = 1'b0;
        if (op == CMD_ALLOC) begin
            while (i < n && !hit) begin
                if (!used_blocks[i]) begin
                    used_blocks[i] = 1'b1;
                    ans.granted = 1'b1;
                    ans.index = i[INDEX_W-1:0];
                    ans.offset = running[OFFSET_W-1:0];
                    hit = 1'b1;
                end
                else begin
                    running = running + 64'(cfg_bytes);
                    i++;
                end
            end
            if (!hit)
                ans.status = STATUS_FULL;
        end
        else if (op == CMD_FREE) begin
            while (i < n && !hit) begin
                if (running == longint'(target)) begin
                    used_blocks[i] = 1'b0;
                    ans.index = i[INDEX_W-1:0];
                    hit = 1'b1;
                end
                else begin
                    running = running + 64'(cfg_bytes);
                    i++;
                end
            end
            if (!hit)
                ans.status = STATUS_BAD_OFFSET;
        end
        else if (op == CMD_FREE_ALL) begin
            used_blocks = '0;
        end
        return ans;
    endfunction

    function automatic int pause_len();
        int r;
        r = $urandom_range(99);
        if (calm || r < 65)
            return 0;
        else if (r < 93)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    task automatic report_fault(input string msg);
        if (fault_count < 10)
            $display("%s", msg);
        fault_count++;
    endtask

    // Request driver: take a beat, then present the next queued command.
    always @(posedge clk) begin : req_driver
        pool_req_t nxt;
        if (rst_n) begin
            if (req_valid && !req_stall)
                pending_answers.push_back(pool_answer(cmd, free_offset));
            if (!req_valid || !req_stall) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    req_valid <= 1'b0;
                end
                else if (queued_requests.size() != 0) begin
                    nxt = queued_requests.pop_front();
                    cmd <= nxt.op;
                    free_offset <= nxt.offset;
                    req_valid <= 1'b1;
                    send_gap <= pause_len();
                end
                else begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Answer-side stall pattern, with the long hold when one is asked for.
    always @(posedge clk) begin : rsp_staller
        int g;
        if (rst_n) begin
            if (hold_done != hold_asks) begin
                hold_done <= hold_asks;
                stall_left <= HOLD_CYCLES - 1;
                rsp_stall <= 1'b1;
            end
            else if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                rsp_stall <= 1'b1;
            end
            else if (rsp_valid && !rsp_stall) begin
                g = pause_len();
                stall_left <= (g == 0) ? 0 : g - 1;
                rsp_stall <= (g != 0);
            end
            else begin
                rsp_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin : rsp_monitor
        pool_rsp_t want;
        pool_rsp_t got;
        if (rst_n && rsp_valid && !rsp_stall) begin
            got.granted = granted;
            got.index = block_index;
            got.offset = block_offset;
            got.status = status;
            if (pending_answers.size() == 0) begin
                report_fault($sformatf("unexpected answer: granted %0d index %0d offset %0d status %0d",
                                       got.granted, got.index, got.offset, got.status));
            end
            else begin
                want = pending_answers.pop_front();
                if (got.granted !== want.granted || got.index !== want.index ||
                    got.offset !== want.offset || got.status !== want.status)
                    report_fault($sformatf({"answer mismatch at %0t: granted %0d/%0d ",
                                            "index %0d/%0d offset %0d/%0d status %0d/%0d ",
                                            "(expected/actual)"}, $time,
                                           want.granted, got.granted, want.index, got.index,
                                           want.offset, got.offset, want.status, got.status));
            end
        end
    end

    always @(posedge clk) begin : watchdog
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
        else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic queue_req(input logic [CMD_W-1:0] op, input logic [OFFSET_W-1:0] offset);
        pool_req_t r;
        r.op = op;
        r.offset = offset;
        queued_requests.push_back(r);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (queued_requests.size() != 0 || req_valid || pending_answers.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_BLOCK_COUNT)
            cfg_count = val[COUNT_W-1:0];
        else
            cfg_bytes = val[BYTES_W-1:0];
    endtask

    // Mostly allocations and frees at real block starts, plus noise.
    task automatic fill_random(input int items, input int alloc_pct);
        int              r;
        int              k;
        longint unsigned span;
        logic [OFFSET_W-1:0] noise;
        repeat (items) begin
            r = $urandom_range(99);
            noise = OFFSET_W'($urandom());
            if (r < alloc_pct) begin
                queue_req(CMD_ALLOC, noise);
            end
            else if (r < alloc_pct + 7) begin
                queue_req(CMD_FREE, noise);
            end
            else if (r < 97) begin
                k = $urandom_range(active_count() + 1);
                span = 64'(k);
                span = span * 64'(cfg_bytes);
                if ($urandom_range(19) == 0)
                    span = span + 1;
                queue_req(CMD_FREE, span[OFFSET_W-1:0]);
            end
            else if (r < 99) begin
                queue_req(CMD_FREE_ALL, noise);
            end
            else begin
                queue_req(CMD_UNUSED, noise);
            end
        end
    endtask

    task automatic run_phase(input logic [COUNT_W-1:0] count, input logic [BYTES_W-1:0] bytes,
                             input int items, input int alloc_pct, input bit flood);
        logic [JUNK_W-1:0] junk;
        junk = JUNK_W'($urandom());
        wait_drained();
        write_reg(REG_BLOCK_COUNT, {junk, count});
        write_reg(REG_BLOCK_BYTES, bytes);
        @(negedge clk);
        calm = flood || ($urandom_range(3) == 0);
        if (flood)
            hold_asks++;
        fill_random(items, alloc_pct);
    endtask

    initial begin : sequencer
        int total;
        int items;
        logic [COUNT_W-1:0] count;
        logic [BYTES_W-1:0] bytes;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset geometry: 64 blocks of 256 bytes.
        queue_req(CMD_ALLOC, '1);
        queue_req(CMD_ALLOC, '0);
        queue_req(CMD_ALLOC, 22'h2AAAAA);
        queue_req(CMD_FREE, 22'd256);
        queue_req(CMD_ALLOC, 22'h155555);
        queue_req(CMD_FREE, 22'd100);
        queue_req(CMD_FREE, '1);
        queue_req(CMD_FREE, 22'd0);
        queue_req(CMD_FREE, 22'd16128);
        queue_req(CMD_FREE, 22'd16384);
        queue_req(CMD_FREE_ALL, '1);
        queue_req(CMD_UNUSED, '1);
        queue_req(CMD_ALLOC, '0);
        queue_req(CMD_FREE, 22'd512);
        total = 14;

        run_phase(7'd1, 16'd1, 100, 50, 1'b0);
        run_phase(7'd0, 16'd5, 50, 50, 1'b0);
        run_phase(7'd100, 16'hFFFF, 200, 60, 1'b0);
        run_phase(7'd64, 16'd0, 120, 50, 1'b0);
        run_phase(7'd8, 16'd3, 200, 50, 1'b1);
        run_phase(7'd127, 16'd1, 200, 55, 1'b0);
        run_phase(7'd2, 16'hFFFF, 120, 50, 1'b0);
        total += 990;

        while (total < TARGET_ITEMS) begin
            items = $urandom_range(200, 100);
            count = ($urandom_range(9) < 7) ? 7'($urandom_range(64, 1)) : 7'($urandom());
            bytes = ($urandom_range(1) == 0) ? 16'($urandom_range(300, 1)) : 16'($urandom());
            run_phase(count, bytes, items, $urandom_range(65, 35), 1'b0);
            total += items;
        end

        wait_drained();
        if (fault_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
